// File: rtl/sbt_pkg.sv
// shared types, character codes and helpers of the script byte tokenizer
`timescale 1ns / 1ps

package sbt_pkg;

   localparam int MAX_RESULTS  = 4;
   localparam int RES_CNT_BITS = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   typedef enum logic [4:0] {
      MODE_BETWEEN  = 5'b00001,
      MODE_LINECMT  = 5'b00010,
      MODE_BLOCKCMT = 5'b00100,
      MODE_WORD     = 5'b01000,
      MODE_QUOTED   = 5'b10000
   } lex_mode_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_start;
      logic       token_end;
      logic       quoted;
      logic       crossed_line;
      logic       script_end;
   } rsp_flags_type;

   localparam int FLAG_BITS = $bits(rsp_flags_type);

   function automatic logic is_single(input logic [7:0] c);
      return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_BAR) || (c == CH_EQUAL);
   endfunction

   function automatic rsp_flags_type mk_entry(input logic [7:0] b, input logic valid,
                                              input logic start, input logic stop,
                                              input logic q, input logic crossed,
                                              input logic send);
      rsp_flags_type e;
      e.token_byte   = b;
      e.byte_valid   = valid;
      e.token_start  = start;
      e.token_end    = stop;
      e.quoted       = q;
      e.crossed_line = crossed;
      e.script_end   = send;
      return e;
   endfunction

endpackage

// File: rtl/sbt_req_if.sv
// byte input channel of the script byte tokenizer
`timescale 1ns / 1ps

interface sbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// File: rtl/sbt_rsp_if.sv
// token result channel of the script byte tokenizer
`timescale 1ns / 1ps

interface sbt_rsp_if #(
   parameter int LINE_BITS = 20
);
   logic                 valid;
   logic                 ready;
   logic [7:0]           token_byte;
   logic                 byte_valid;
   logic                 token_start;
   logic                 token_end;
   logic                 quoted;
   logic [LINE_BITS-1:0] line_number;
   logic                 crossed_line;
   logic                 script_end;
   logic                 last;

   modport source (output valid, output token_byte, output byte_valid, output token_start,
                   output token_end, output quoted, output line_number,
                   output crossed_line, output script_end, output last, input ready);
   modport sink (input valid, input token_byte, input byte_valid, input token_start,
                 input token_end, input quoted, input line_number,
                 input crossed_line, input script_end, input last, output ready);
endinterface

// File: rtl/sbt_lexer.sv
// front end: accepts script bytes and lexes each into a bundle of up to four results
`timescale 1ns / 1ps

module sbt_lexer import sbt_pkg::*; #(
   parameter int MAX_TOKEN_LEN = 4095,
   parameter int LINE_BITS     = 20,
   parameter int BUNDLE_W      = RES_CNT_BITS + MAX_RESULTS * (FLAG_BITS + LINE_BITS)
) (
   input  logic                clock,
   input  logic                reset,
   sbt_req_if.sink             req,
   output logic                push_valid,
   input  logic                push_ready,
   output logic [BUNDLE_W-1:0] push_data
);

   localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);

   lex_mode_type         mode_ff, mode_in;
   logic                 sp_ff, sp_in;
   logic                 sit_ff, sit_in;
   logic                 star_ff, star_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic                 crossed_ff, crossed_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic                 drop_ff, drop_in;

   rsp_flags_type [MAX_RESULTS-1:0]        ent;
   logic [MAX_RESULTS-1:0][LINE_BITS-1:0]  lin;
   logic [RES_CNT_BITS-1:0]                n;

   logic [7:0] c;
   logic       fin;
   logic       accept;
   logic       skip_main;
   logic       do_between;
   logic       tb_do;
   logic       tb_q;
   logic       first;
   logic       cut;
   logic       sep;

   assign c      = req.data_byte;
   assign fin    = req.final_byte;
   assign accept = req.valid && push_ready;
   assign sep    = (c <= CH_SPACE) || is_single(c) || (c == CH_SEMI);

   assign req.ready  = push_ready;
   assign push_valid = accept && (n != '0);
   assign push_data  = {n, ent, lin};

   always_comb begin
      mode_in    = mode_ff;
      sp_in      = sp_ff;
      sit_in     = sit_ff;
      star_in    = star_ff;
      line_in    = line_ff;
      crossed_in = crossed_ff;
      len_in     = len_ff;
      drop_in    = drop_ff;
      ent        = '0;
      lin        = '0;
      n          = '0;
      skip_main  = 1'b0;
      do_between = 1'b0;
      tb_do      = 1'b0;
      tb_q       = 1'b0;
      first      = 1'b0;
      cut        = 1'b0;

      if (drop_ff) begin
         drop_in   = 1'b0;
         skip_main = 1'b1;
      end else if (sp_ff || sit_ff) begin
         sp_in  = 1'b0;
         sit_in = 1'b0;
         if ((c == CH_SLASH) || (c == CH_STAR)) begin
            if (sit_ff) begin
               ent[n[1:0]] = mk_entry(8'h00, 1'b0, len_in == '0, 1'b1,
                                      mode_in == MODE_QUOTED, crossed_in, 1'b0);
               lin[n[1:0]] = line_in;
               n           = n + RES_CNT_BITS'(1);
               len_in      = '0;
               crossed_in  = 1'b0;
            end
            mode_in   = (c == CH_SLASH) ? MODE_LINECMT : MODE_BLOCKCMT;
            star_in   = (c == CH_STAR);
            skip_main = 1'b1;
         end else begin
            // held slash becomes a word byte
            first  = (len_in == '0);
            len_in = len_in + LEN_BITS'(1);
            cut    = (len_in >= LEN_BITS'(MAX_TOKEN_LEN));
            ent[n[1:0]] = mk_entry(CH_SLASH, 1'b1, first, cut, 1'b0, crossed_in, 1'b0);
            lin[n[1:0]] = line_in;
            n           = n + RES_CNT_BITS'(1);
            if (cut) begin
               mode_in    = MODE_BETWEEN;
               len_in     = '0;
               crossed_in = 1'b0;
            end else begin
               mode_in = MODE_WORD;
            end
         end
      end

      if (!skip_main) begin
         case (mode_in)
            MODE_LINECMT: begin
               if (c == CH_NEWLINE) begin
                  if (line_in != '1) line_in = line_in + LINE_BITS'(1);
                  crossed_in = 1'b1;
                  mode_in    = MODE_BETWEEN;
               end
            end
            MODE_BLOCKCMT: begin
               if (star_in && (c == CH_SLASH)) begin
                  star_in = 1'b0;
                  mode_in = MODE_BETWEEN;
               end else begin
                  star_in = (c == CH_STAR);
                  if (c == CH_NEWLINE) begin
                     if (line_in != '1) line_in = line_in + LINE_BITS'(1);
                     crossed_in = 1'b1;
                  end
               end
            end
            MODE_WORD: begin
               if (sep) begin
                  ent[n[1:0]] = mk_entry(8'h00, 1'b0, len_in == '0, 1'b1, 1'b0,
                                         crossed_in, 1'b0);
                  lin[n[1:0]] = line_in;
                  n           = n + RES_CNT_BITS'(1);
                  mode_in     = MODE_BETWEEN;
                  len_in      = '0;
                  crossed_in  = 1'b0;
                  do_between  = 1'b1;
               end else if ((c == CH_SLASH) && !fin) begin
                  sit_in = 1'b1;
               end else begin
                  tb_do = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (c == CH_QUOTE) begin
                  ent[n[1:0]] = mk_entry(8'h00, 1'b0, len_in == '0, 1'b1, 1'b1,
                                         crossed_in, 1'b0);
                  lin[n[1:0]] = line_in;
                  n           = n + RES_CNT_BITS'(1);
                  mode_in     = MODE_BETWEEN;
                  len_in      = '0;
                  crossed_in  = 1'b0;
               end else begin
                  tb_do = 1'b1;
                  tb_q  = 1'b1;
               end
            end
            default: begin
               mode_in    = MODE_BETWEEN;
               do_between = 1'b1;
            end
         endcase

         if (do_between) begin
            if (c <= CH_SPACE) begin
               if (c == CH_NEWLINE) begin
                  if (line_in != '1) line_in = line_in + LINE_BITS'(1);
                  crossed_in = 1'b1;
               end
            end else if (c == CH_SEMI) begin
               mode_in = MODE_LINECMT;
            end else if ((c == CH_SLASH) && !fin) begin
               sp_in = 1'b1;
            end else if (c == CH_QUOTE) begin
               mode_in = MODE_QUOTED;
               len_in  = '0;
            end else if (is_single(c)) begin
               ent[n[1:0]] = mk_entry(c, 1'b1, 1'b1, 1'b1, 1'b0, crossed_in, 1'b0);
               lin[n[1:0]] = line_in;
               n           = n + RES_CNT_BITS'(1);
               crossed_in  = 1'b0;
            end else begin
               tb_do = 1'b1;
            end
         end

         if (tb_do) begin
            first  = (len_in == '0);
            len_in = len_in + LEN_BITS'(1);
            cut    = (len_in >= LEN_BITS'(MAX_TOKEN_LEN));
            ent[n[1:0]] = mk_entry(c, 1'b1, first, cut, tb_q, crossed_in, 1'b0);
            lin[n[1:0]] = line_in;
            n           = n + RES_CNT_BITS'(1);
            if (cut) begin
               mode_in    = MODE_BETWEEN;
               len_in     = '0;
               crossed_in = 1'b0;
               if (tb_q) drop_in = 1'b1;
            end else begin
               mode_in = tb_q ? MODE_QUOTED : MODE_WORD;
            end
         end
      end

      if (fin) begin
         if ((mode_in == MODE_WORD) || (mode_in == MODE_QUOTED)) begin
            ent[n[1:0]] = mk_entry(8'h00, 1'b0, len_in == '0, 1'b1,
                                   mode_in == MODE_QUOTED, crossed_in, 1'b0);
            lin[n[1:0]] = line_in;
            n           = n + RES_CNT_BITS'(1);
         end
         ent[n[1:0]] = mk_entry(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
         lin[n[1:0]] = line_in;
         n           = n + RES_CNT_BITS'(1);
         mode_in    = MODE_BETWEEN;
         sp_in      = 1'b0;
         sit_in     = 1'b0;
         star_in    = 1'b0;
         line_in    = LINE_BITS'(1);
         crossed_in = 1'b0;
         len_in     = '0;
         drop_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_BETWEEN;
         sp_ff      <= 1'b0;
         sit_ff     <= 1'b0;
         star_ff    <= 1'b0;
         line_ff    <= LINE_BITS'(1);
         crossed_ff <= 1'b0;
         len_ff     <= '0;
         drop_ff    <= 1'b0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         sp_ff      <= sp_in;
         sit_ff     <= sit_in;
         star_ff    <= star_in;
         line_ff    <= line_in;
         crossed_ff <= crossed_in;
         len_ff     <= len_in;
         drop_ff    <= drop_in;
      end
   end

endmodule

// File: rtl/sbt_queue.sv
// short bundle queue between the lexer and the result emitter
`timescale 1ns / 1ps

module sbt_queue import sbt_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [QUEUE_DEPTH-1:0][WIDTH-1:0] mem_ff;
   logic [QPTR_BITS-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]              count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QCNT_BITS'(1);
      if (!do_push && do_pop) count_in = count_ff - QCNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: rtl/sbt_emitter.sv
// back end: holds one bundle and sends its results one transaction at a time
`timescale 1ns / 1ps

module sbt_emitter import sbt_pkg::*; #(
   parameter int LINE_BITS = 20,
   parameter int BUNDLE_W  = RES_CNT_BITS + MAX_RESULTS * (FLAG_BITS + LINE_BITS)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  logic [BUNDLE_W-1:0] pop_data,
   sbt_rsp_if.source           rsp
);

   logic [BUNDLE_W-1:0] cur_ff, cur_in;
   logic [1:0]          idx_ff, idx_in;
   logic                busy_ff, busy_in;

   rsp_flags_type [MAX_RESULTS-1:0]       ent;
   logic [MAX_RESULTS-1:0][LINE_BITS-1:0] lin;
   logic [RES_CNT_BITS-1:0]               cnt;
   rsp_flags_type                         sel;
   logic                                  is_last;
   logic                                  taken;

   assign {cnt, ent, lin} = cur_ff;
   assign sel       = ent[idx_ff];
   assign is_last   = (idx_ff == 2'(cnt - RES_CNT_BITS'(1)));
   assign taken     = busy_ff && rsp.ready;
   assign pop_ready = !busy_ff || (taken && is_last);

   assign rsp.valid        = busy_ff;
   assign rsp.token_byte   = sel.token_byte;
   assign rsp.byte_valid   = sel.byte_valid;
   assign rsp.token_start  = sel.token_start;
   assign rsp.token_end    = sel.token_end;
   assign rsp.quoted       = sel.quoted;
   assign rsp.crossed_line = sel.crossed_line;
   assign rsp.script_end   = sel.script_end;
   assign rsp.line_number  = lin[idx_ff];
   assign rsp.last         = is_last;

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (pop_ready) begin
         busy_in = pop_valid;
         cur_in  = pop_data;
         idx_in  = '0;
      end else if (taken) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// File: rtl/script_byte_tokenizer_core.sv
// top level of the streaming script byte tokenizer
//
// req_chan carries one script byte per transaction with a final_byte flag.
// rsp_chan carries token results: token bytes with start, end and quoted
// marks, the current line and whether a newline came before the token, plus
// word and string close results and one script_end result after the final
// byte. last marks the final result that a byte caused.
// A byte gives zero to four results. While the queue has space the lexer
// takes one byte per cycle and pushes its results as one bundle into a
// two-entry queue; while rsp_chan is ready the emitter sends one result per
// cycle, so bytes with at most one result stream at one per cycle and a byte
// with several results holds the result channel until its last is taken.
// A byte's bundle is registered in the queue, then in the emitter register.
// When rsp_chan stalls, the emitter holds its result, the queue fills and then
// req_chan.ready drops until space frees up; nothing is lost or repeated.
// Reset (synchronous) empties the queue and emitter and puts the lexer
// between tokens at line 1; a final byte returns the lexer to that state too.
`timescale 1ns / 1ps

module script_byte_tokenizer_core import sbt_pkg::*; #(
   parameter int MAX_TOKEN_LEN = 4095,
   parameter int LINE_BITS     = 20
) (
   input  logic      clock,
   input  logic      reset,
   sbt_req_if.sink   req_chan,
   sbt_rsp_if.source rsp_chan
);

   localparam int BUNDLE_W = RES_CNT_BITS + MAX_RESULTS * (FLAG_BITS + LINE_BITS);

   logic                push_valid;
   logic                push_ready;
   logic [BUNDLE_W-1:0] push_data;
   logic                pop_valid;
   logic                pop_ready;
   logic [BUNDLE_W-1:0] pop_data;

   sbt_lexer #(
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
      .LINE_BITS     (LINE_BITS),
      .BUNDLE_W      (BUNDLE_W)
   ) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sbt_queue #(
      .WIDTH (BUNDLE_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   sbt_emitter #(
      .LINE_BITS (LINE_BITS),
      .BUNDLE_W  (BUNDLE_W)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_chan)
   );

endmodule

// File: verif/tb.sv
// testbench of the script byte tokenizer with a self-checking token predictor
`timescale 1ns / 1ps

module tb import sbt_pkg::*; ();

   localparam int LB      = 20;
   localparam int MAX_TOK = 4095;

   typedef struct packed {
      logic [7:0]    tok;
      logic          valid;
      logic          start;
      logic          stop;
      logic          quoted;
      logic [LB-1:0] line;
      logic          crossed;
      logic          send;
      logic          last;
   } token_result_type;

   class token_tracker_type;
      lex_mode_type     mode;
      bit               pend_slash;
      bit               word_slash;
      bit               star_open;
      bit               drop_one;
      bit               crossed;
      bit [LB-1:0]      line_no;
      int unsigned      tok_len;
      token_result_type due_results[$];
      token_result_type step_results[$];
      int               errors;
      int               checked;

      function new();
         errors = 0;
         checked = 0;
         restart();
      endfunction

      function void restart();
         mode = MODE_BETWEEN;
         pend_slash = 0;
         word_slash = 0;
         star_open = 0;
         drop_one = 0;
         crossed = 0;
         line_no = 1;
         tok_len = 0;
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      function bit single_char(logic [7:0] c);
         return c == CH_LBRACE || c == CH_RBRACE || c == CH_BAR || c == CH_EQUAL;
      endfunction

      function void add_result(logic [7:0] b, bit v, bit s, bit e, bit q, bit x, bit send);
         token_result_type r;
         if (step_results.size() >= MAX_RESULTS)
            return;
         r.tok = b;
         r.valid = v;
         r.start = s;
         r.stop = e;
         r.quoted = q;
         r.line = line_no;
         r.crossed = x;
         r.send = send;
         r.last = 0;
         step_results.push_back(r);
      endfunction

      function void new_line();
         if (line_no != {LB{1'b1}})
            line_no++;
         crossed = 1;
      endfunction

      function void close_tok();
         add_result(8'h00, 0, tok_len == 0, 1, mode == MODE_QUOTED, crossed, 0);
         mode = MODE_BETWEEN;
         tok_len = 0;
         crossed = 0;
      endfunction

      function void tok_byte(logic [7:0] c, bit q);
         bit first;
         bit cut;
         first = (tok_len == 0);
         tok_len++;
         cut = (tok_len >= MAX_TOK);
         add_result(c, 1, first, cut, q, crossed, 0);
         if (cut) begin
            mode = MODE_BETWEEN;
            tok_len = 0;
            crossed = 0;
            if (q)
               drop_one = 1;
         end else begin
            mode = q ? MODE_QUOTED : MODE_WORD;
         end
      endfunction

      function void lex_gap(logic [7:0] c, bit fin);
         if (c <= CH_SPACE) begin
            if (c == CH_NEWLINE)
               new_line();
         end else if (c == CH_SEMI) begin
            mode = MODE_LINECMT;
         end else if (c == CH_SLASH && !fin) begin
            pend_slash = 1;
         end else if (c == CH_QUOTE) begin
            mode = MODE_QUOTED;
            tok_len = 0;
         end else if (single_char(c)) begin
            add_result(c, 1, 1, 1, 0, crossed, 0);
            crossed = 0;
         end else begin
            tok_byte(c, 0);
         end
      endfunction

      function void lex_in_word(logic [7:0] c, bit fin);
         if (c <= CH_SPACE || single_char(c) || c == CH_SEMI) begin
            close_tok();
            lex_gap(c, fin);
         end else if (c == CH_SLASH && !fin) begin
            word_slash = 1;
         end else begin
            tok_byte(c, 0);
         end
      endfunction

      function void after_slash(logic [7:0] c, bit fin);
         tok_byte(CH_SLASH, 0);
         if (mode == MODE_WORD)
            lex_in_word(c, fin);
         else
            lex_gap(c, fin);
      endfunction

      function void lex_byte(logic [7:0] c, bit fin);
         if (drop_one) begin
            drop_one = 0;
            return;
         end
         if (pend_slash) begin
            pend_slash = 0;
            if (c == CH_SLASH) begin
               mode = MODE_LINECMT;
            end else if (c == CH_STAR) begin
               mode = MODE_BLOCKCMT;
               star_open = 1;
            end else begin
               after_slash(c, fin);
            end
            return;
         end
         if (word_slash) begin
            word_slash = 0;
            if (c == CH_SLASH || c == CH_STAR) begin
               close_tok();
               mode = (c == CH_SLASH) ? MODE_LINECMT : MODE_BLOCKCMT;
               star_open = (c == CH_STAR);
            end else begin
               after_slash(c, fin);
            end
            return;
         end
         case (mode)
            MODE_LINECMT: begin
               if (c == CH_NEWLINE) begin
                  new_line();
                  mode = MODE_BETWEEN;
               end
            end
            MODE_BLOCKCMT: begin
               if (star_open && c == CH_SLASH) begin
                  star_open = 0;
                  mode = MODE_BETWEEN;
               end else begin
                  star_open = (c == CH_STAR);
                  if (c == CH_NEWLINE)
                     new_line();
               end
            end
            MODE_WORD: lex_in_word(c, fin);
            MODE_QUOTED: begin
               if (c == CH_QUOTE)
                  close_tok();
               else
                  tok_byte(c, 1);
            end
            default: begin
               mode = MODE_BETWEEN;
               lex_gap(c, fin);
            end
         endcase
      endfunction

      function void note_byte(logic [7:0] c, bit fin);
         step_results.delete();
         lex_byte(c, fin);
         if (fin) begin
            if (mode == MODE_WORD || mode == MODE_QUOTED)
               close_tok();
            add_result(8'h00, 0, 0, 0, 0, 0, 1);
            restart();
         end
         if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1;
         foreach (step_results[i])
            due_results.push_back(step_results[i]);
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at result %0d: %s", checked, msg);
      endtask

      task compare(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_result(token_result_type got);
         token_result_type want;
         if (due_results.size() == 0) begin
            report($sformatf("unexpected result, byte %02h", got.tok));
            return;
         end
         want = due_results.pop_front();
         compare("token_byte", 32'(got.tok), 32'(want.tok));
         compare("byte_valid", 32'(got.valid), 32'(want.valid));
         compare("token_start", 32'(got.start), 32'(want.start));
         compare("token_end", 32'(got.stop), 32'(want.stop));
         compare("quoted", 32'(got.quoted), 32'(want.quoted));
         compare("line_number", 32'(got.line), 32'(want.line));
         compare("crossed_line", 32'(got.crossed), 32'(want.crossed));
         compare("script_end", 32'(got.send), 32'(want.send));
         compare("last", 32'(got.last), 32'(want.last));
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit send_idle = 1'b0;
   bit take_idle = 1'b0;
   logic [7:0] script_q[$];
   token_tracker_type tracker = new();

   sbt_req_if req();
   sbt_rsp_if #(.LINE_BITS(LB)) rsp();

   script_byte_tokenizer_core #(
      .MAX_TOKEN_LEN(MAX_TOK),
      .LINE_BITS(LB)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] word_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(33, 255));
      while (c == CH_SEMI || c == CH_QUOTE || c == CH_SLASH || c == CH_LBRACE ||
             c == CH_RBRACE || c == CH_BAR || c == CH_EQUAL);
      return c;
   endfunction

   function automatic logic [7:0] byte_except(logic [7:0] x);
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (c == x);
      return c;
   endfunction

   function automatic logic [7:0] single_char();
      case ($urandom_range(0, 3))
         0: return CH_LBRACE;
         1: return CH_RBRACE;
         2: return CH_BAR;
         default: return CH_EQUAL;
      endcase
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: return CH_NEWLINE;
         1: return CH_SPACE;
         default: return 8'($urandom_range(0, 32));
      endcase
   endfunction

   function automatic logic [7:0] comment_char();
      case ($urandom_range(0, 2))
         0: return CH_STAR;
         1: return CH_NEWLINE;
         default: return byte_except(CH_SLASH);
      endcase
   endfunction

   task automatic add_text(string s);
      foreach (s[i])
         script_q.push_back(s[i]);
   endtask

   task automatic add_fragment();
      int n;
      n = $urandom_range(0, 8);
      case ($urandom_range(0, 11))
         0, 1: begin
            repeat (n / 2 + 1) script_q.push_back(word_char());
            if ($urandom_range(0, 3) == 0) begin
               script_q.push_back(CH_SLASH);
               script_q.push_back(word_char());
            end
         end
         2: begin
            script_q.push_back(CH_QUOTE);
            repeat (n) script_q.push_back(byte_except(CH_QUOTE));
            script_q.push_back(CH_QUOTE);
         end
         3: begin
            script_q.push_back(CH_SEMI);
            repeat (n) script_q.push_back(byte_except(CH_NEWLINE));
            script_q.push_back(CH_NEWLINE);
         end
         4: begin
            add_text("//");
            repeat (n) script_q.push_back(byte_except(CH_NEWLINE));
            script_q.push_back(CH_NEWLINE);
         end
         5: begin
            add_text("/*");
            repeat (n) script_q.push_back(comment_char());
            add_text("*/");
         end
         6: script_q.push_back(single_char());
         7, 8: repeat (n / 3 + 1) script_q.push_back(blank_char());
         9: begin
            repeat (n / 3 + 1) script_q.push_back(word_char());
            script_q.push_back(CH_SLASH);
            if ($urandom_range(0, 1) == 0) begin
               script_q.push_back(CH_SLASH);
               repeat (n) script_q.push_back(byte_except(CH_NEWLINE));
               script_q.push_back(CH_NEWLINE);
            end else begin
               script_q.push_back(CH_STAR);
               repeat (n) script_q.push_back(comment_char());
               add_text("*/");
            end
         end
         10: repeat (n / 2 + 1) script_q.push_back(8'($urandom_range(0, 255)));
         default: begin
            case ($urandom_range(0, 2))
               0: script_q.push_back(CH_QUOTE);
               1: script_q.push_back(CH_SEMI);
               default: add_text("/*");
            endcase
            repeat (n) script_q.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if (send_idle && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data_byte <= b;
      req.final_byte <= fin;
      do
         @(posedge clock);
      while (!req.ready);
      tracker.note_byte(b, fin);
   endtask

   task automatic wait_results_done();
      req.valid <= 1'b0;
      do
         @(posedge clock);
      while (tracker.pending() != 0);
   endtask

   task automatic send_script();
      foreach (script_q[i]) begin
         if (send_idle && $urandom_range(0, 39) == 0)
            wait_results_done();
         send_byte(script_q[i], i == script_q.size() - 1);
      end
      script_q.delete();
   endtask

   task automatic random_scripts(input int target, inout int sent);
      while (sent < target) begin
         repeat ($urandom_range(1, 8)) begin
            add_fragment();
            if ($urandom_range(0, 2) == 0)
               script_q.push_back(blank_char());
         end
         sent += script_q.size();
         send_script();
      end
   endtask

   initial begin
      int stall;
      token_result_type got;
      stall = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            got.tok = rsp.token_byte;
            got.valid = rsp.byte_valid;
            got.start = rsp.token_start;
            got.stop = rsp.token_end;
            got.quoted = rsp.quoted;
            got.line = rsp.line_number;
            got.crossed = rsp.crossed_line;
            got.send = rsp.script_end;
            got.last = rsp.last;
            tracker.check_result(got);
         end
         if (stall == 0 && take_idle && $urandom_range(0, 5) == 0)
            stall = $urandom_range(1, 11);
         if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      int sent;
      sent = 0;
      req.valid <= 1'b0;
      req.data_byte <= 8'h00;
      req.final_byte <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed scripts
      send_idle = 1'b1;
      take_idle = 1'b1;
      script_q.push_back(8'h00);
      add_text("a");
      script_q.push_back(8'hFF);
      add_text("{}|=\n\"\";c\n/*/b/x\"q\n\"w/");
      send_script();
      add_text("/");
      send_script();
      wait_results_done();

      random_scripts(80, sent);
      wait_results_done();
      send_idle = 1'b0;
      take_idle = 1'b0;
      random_scripts(135, sent);

      req.valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
